>>> rtl/core/pm_pkg.sv
// Package for the polynomial multiplier: sizes, function codes, controller
// states and the command/status structs between controller and datapath.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pm_pkg;

  localparam int MAX_DEG   = 31;
  localparam int COEF_BITS = 16;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int POWER_W = 5;
  localparam int COEFF_W = 16;
  localparam int DEG_W   = 5;
  localparam int PCOEF_W = 37;
  localparam int PPOW_W  = 6;

  // Derived sizes.
  localparam int IDX_W   = (MAX_DEG < 1) ? 1 : $clog2(MAX_DEG + 1);
  localparam int DEPTH   = MAX_DEG + 1;
  localparam int PROD_W  = 2 * COEF_BITS;
  localparam int N_W     = IDX_W + 1;
  localparam int PIPE_DEPTH = 2;

  // Configuration register indexes and bus sizes.
  localparam int REG_DEGREE_A = 0;
  localparam int REG_DEGREE_B = 1;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A   = 2'd0,
    FUNC_LOAD_B   = 2'd1,
    FUNC_MULTIPLY = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_a_addr;
    logic [IDX_W-1:0]  rd_b_addr;
    logic              acc_clr;
    logic              emit;
    logic [PPOW_W-1:0] power;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // A degree above the store saturates to the top entry.
  function automatic logic [IDX_W-1:0] clamp_deg(input logic [DEG_W-1:0] d);
    if (32'(d) > MAX_DEG) begin
      return IDX_W'(MAX_DEG);
    end else begin
      return IDX_W'(d);
    end
  endfunction

endpackage

>>> rtl/core/pm_ctrl.sv
// Controller of the polynomial multiplier: takes input transfers, walks the
// product powers and the convolution terms, and drives the datapath.
// Depends on pm_pkg.
`timescale 1ns / 1ps

module pm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pm_pkg::FUNC_W-1:0]  func,
  input  logic [pm_pkg::POWER_W-1:0] power,
  input  logic [pm_pkg::DEG_W-1:0]   degree_a,
  input  logic [pm_pkg::DEG_W-1:0]   degree_b,
  input  pm_pkg::dp_status_t         status,
  output pm_pkg::dp_cmd_t            cmd
);

  pm_pkg::state_t                state, state_next;
  logic [pm_pkg::N_W-1:0]        n, n_next;
  logic [pm_pkg::IDX_W-1:0]      j, j_next;
  logic [pm_pkg::IDX_W-1:0]      jhi, jhi_next;
  logic [$clog2(pm_pkg::PIPE_DEPTH)-1:0] drain, drain_next;

  logic [pm_pkg::IDX_W-1:0] da, db;
  logic [pm_pkg::N_W-1:0]   da_w, db_w;
  logic                     accept, power_ok;

  assign da       = pm_pkg::clamp_deg(degree_a);
  assign db       = pm_pkg::clamp_deg(degree_b);
  assign da_w     = pm_pkg::N_W'(da);
  assign db_w     = pm_pkg::N_W'(db);
  assign in_ready = (state == pm_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign power_ok = (32'(power) <= pm_pkg::MAX_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pm_pkg::ST_IDLE;
      n     <= '0;
      j     <= '0;
      jhi   <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      j     <= j_next;
      jhi   <= jhi_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    j_next     = j;
    jhi_next   = jhi;
    drain_next = drain;

    cmd           = '0;
    cmd.rd_a_addr = j;
    cmd.rd_b_addr = pm_pkg::IDX_W'(n - pm_pkg::N_W'(j));
    cmd.power     = pm_pkg::PPOW_W'(n);
    cmd.last      = (n == '0);

    case (state)
      pm_pkg::ST_IDLE: begin
        if (accept) begin
          case (func)
            pm_pkg::FUNC_LOAD_A: cmd.wr_a = power_ok;
            pm_pkg::FUNC_LOAD_B: cmd.wr_b = power_ok;
            pm_pkg::FUNC_MULTIPLY: begin
              n_next     = da_w + db_w;
              state_next = pm_pkg::ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      pm_pkg::ST_SETUP: begin
        // Terms run over j from max(0, n-db) to min(da, n).
        cmd.acc_clr = 1'b1;
        j_next      = (n > db_w) ? pm_pkg::IDX_W'(n - db_w) : '0;
        jhi_next    = (n > da_w) ? da : pm_pkg::IDX_W'(n);
        state_next  = pm_pkg::ST_ISSUE;
      end
      pm_pkg::ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (j == jhi) begin
          drain_next = '0;
          state_next = pm_pkg::ST_DRAIN;
        end else begin
          j_next = j + 1'b1;
        end
      end
      pm_pkg::ST_DRAIN: begin
        if (32'(drain) == pm_pkg::PIPE_DEPTH - 1) begin
          state_next = pm_pkg::ST_EMIT;
        end else begin
          drain_next = drain + 1'b1;
        end
      end
      pm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (n == '0) begin
            state_next = pm_pkg::ST_IDLE;
          end else begin
            n_next     = n - 1'b1;
            state_next = pm_pkg::ST_SETUP;
          end
        end
      end
      default: state_next = pm_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/pm_dp.sv
// Datapath of the polynomial multiplier: the two coefficient stores, the
// pipelined multiply-accumulate and the output register.
// Depends on pm_pkg.
`timescale 1ns / 1ps

module pm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pm_pkg::dp_cmd_t                   cmd,
  output pm_pkg::dp_status_t                status,
  input  logic [pm_pkg::POWER_W-1:0]        power,
  input  logic signed [pm_pkg::COEFF_W-1:0] coeff,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pm_pkg::PCOEF_W-1:0] product_coeff,
  output logic [pm_pkg::PPOW_W-1:0]         product_power,
  output logic                              last
);

  logic [pm_pkg::COEF_BITS-1:0] mem_a [pm_pkg::DEPTH];
  logic [pm_pkg::COEF_BITS-1:0] mem_b [pm_pkg::DEPTH];

  logic [pm_pkg::COEF_BITS-1:0]      rd_a, rd_b;
  logic                              rd_valid;
  logic signed [pm_pkg::PROD_W-1:0]  prod;
  logic                              prod_valid;
  logic signed [pm_pkg::PCOEF_W-1:0] acc;
  logic [pm_pkg::IDX_W-1:0]          wr_addr;

  assign wr_addr = power[pm_pkg::IDX_W-1:0];

  // Only the low COEF_BITS of a loaded value are kept.
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= coeff[pm_pkg::COEF_BITS-1:0];
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= coeff[pm_pkg::COEF_BITS-1:0];
    end
    if (cmd.rd_en) begin
      rd_a <= mem_a[cmd.rd_a_addr];
      rd_b <= mem_b[cmd.rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(rd_a) * $signed(rd_b);
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(pm_pkg::PCOEF_W - pm_pkg::PROD_W){prod[pm_pkg::PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid   <= cmd.rd_en;
      prod_valid <= rd_valid;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      product_coeff <= acc;
      product_power <= cmd.power;
      last          <= cmd.last;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

>>> rtl/core/polynomial_multiply_top.sv
// Top level of the polynomial multiplier: configuration registers on an
// APB-style port, and the controller and datapath joined together.
// Depends on pm_pkg, pm_ctrl and pm_dp.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     func, power, coeff
// result    out        out_valid / out_ready   product_coeff, product_power, last
// config    in         psel/penable/pwrite     paddr, pwdata (prdata on reads)
//
// A load keeps the controller idle, so loads stream at one per cycle between multiplies.
// A multiply emits degree_a+degree_b+1 results, highest power first. Each
// result runs setup, T term reads, drain and emit on the single multiply-
// accumulate unit, T being that power's count of convolution terms; the
// coefficient store read and the multiplier are each one registered stage.
// Reset is synchronous and active high; it clears the degrees, the
// controller and the valid flags. The coefficient stores are not cleared.
// A held result stalls the controller only while the output register is
// full; new input is taken once the last result sits in the output register.

module polynomial_multiply_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pm_pkg::FUNC_W-1:0]         func,
  input  logic [pm_pkg::POWER_W-1:0]        power,
  input  logic signed [pm_pkg::COEFF_W-1:0] coeff,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pm_pkg::PCOEF_W-1:0] product_coeff,
  output logic [pm_pkg::PPOW_W-1:0]         product_power,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pm_pkg::PADDR_W-1:0]        paddr,
  input  logic [pm_pkg::PDATA_W-1:0]        pwdata,
  output logic [pm_pkg::PDATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [pm_pkg::DEG_W-1:0] degree_a, degree_b;
  logic                     reg_idx;
  logic                     cfg_wr;
  pm_pkg::dp_cmd_t          cmd;
  pm_pkg::dp_status_t       status;

  // Registers sit on word addresses; bit 2 selects between the two.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_a <= '0;
      degree_b <= '0;
    end else if (cfg_wr) begin
      if (32'(reg_idx) == pm_pkg::REG_DEGREE_A) begin
        degree_a <= pwdata[pm_pkg::DEG_W-1:0];
      end else if (32'(reg_idx) == pm_pkg::REG_DEGREE_B) begin
        degree_b <= pwdata[pm_pkg::DEG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) == pm_pkg::REG_DEGREE_A) begin
      prdata[pm_pkg::DEG_W-1:0] = degree_a;
    end else begin
      prdata[pm_pkg::DEG_W-1:0] = degree_b;
    end
  end

  pm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .power    (power),
    .degree_a (degree_a),
    .degree_b (degree_b),
    .status   (status),
    .cmd      (cmd)
  );

  pm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .power         (power),
    .coeff         (coeff),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_coeff (product_coeff),
    .product_power (product_power),
    .last          (last)
  );

endmodule
